/* rtl/assert_macros.svh */
// Assertion macros for the RTL of the temporal average block.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define TADU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tadu assertion failed");

// Next-cycle implication, disabled while reset is low.
`define TADU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tadu assertion failed");

`endif

/* rtl/tadu_pkg.sv */
// Package for the temporal average / upscale / dither block.
// Geometry constants, payload structs, sequencer states and dither table.
package tadu_pkg;

  localparam int SRC_WIDTH      = 96;
  localparam int SRC_HEIGHT     = 64;
  localparam int HISTORY_FRAMES = 4;
  localparam int SCALE          = 3;

  localparam int PIX_COUNT     = SRC_WIDTH * SRC_HEIGHT;
  localparam int HIST_DEPTH    = PIX_COUNT * HISTORY_FRAMES;
  localparam int DISP_WIDTH    = SRC_WIDTH * SCALE;
  localparam int DISP_HEIGHT   = SRC_HEIGHT * SCALE;
  localparam int BYTES_PER_ROW = (DISP_WIDTH + 7) / 8;

  // A display byte advances the source column by BYTE_STEP plus a phase carry.
  localparam int BYTE_STEP = 8 / SCALE;
  localparam int BYTE_REM  = 8 % SCALE;

  localparam int POS_W   = $clog2(PIX_COUNT);
  localparam int HADDR_W = $clog2(HIST_DEPTH);
  localparam int SLOT_W  = $clog2(HISTORY_FRAMES);
  localparam int ROW_W   = $clog2(DISP_HEIGHT);
  localparam int BCOL_W  = $clog2(BYTES_PER_ROW + 1);
  localparam int SX_W    = $clog2(SRC_WIDTH + 9);
  localparam int PH_W    = $clog2(SCALE + 1);
  localparam int BIT_W   = 4;

  typedef struct packed {
    logic       kind;
    logic [7:0] pixel;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
  } out_t;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WR_WRITE,
    ST_RD_ISSUE,
    ST_RD_DRAIN,
    ST_RD_HOLD
  } state_t;

  // Meta data of one sum-store read in flight during byte assembly.
  typedef struct packed {
    logic             valid;
    logic             col_ok;
    logic [BIT_W-1:0] start;
    logic [BIT_W-1:0] cnt;
  } grp_t;

  // Ordered dither thresholds, indexed [x & 3][y & 3].
  localparam logic [7:0] THRESH [4][4] = '{
    '{8'd15,  8'd195, 8'd60,  8'd240},
    '{8'd135, 8'd75,  8'd180, 8'd120},
    '{8'd45,  8'd225, 8'd30,  8'd210},
    '{8'd165, 8'd105, 8'd150, 8'd90}
  };

endpackage

/* rtl/tadu_ram.sv */
// Generic single-port RAM, write-enable, registered read data.
// No dependencies.
module tadu_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/temporal_average_upscale_dither.sv */
// Temporal box average over the last frames, 3x upscale, 4x4 ordered dither.
// Channels: in (kind + pixel) and out (packed display byte + frame_end),
// both valid/ready; a transaction completes when valid and ready are high.
// kind = write: the pixel enters the running sum store at the next raster
// position; no result. Its steps are accept, then a read-modify-write of the sum
// and history stores, whose reads are issued while idle.
// kind = read: one result with the next display byte, row-major, MSB first.
// Its steps are accept, 3 or 4 sum-store reads (one per source column the byte
// spans, single-port sum store), a drain step and the output load.
// Reset (rst_n low at a clock edge) clears all control state, then a clear
// pass over all HIST_DEPTH (24576) history addresses zeroes both stores;
// in_ready stays low.
// The output register lets pixel writes proceed while a byte waits; a read
// transaction that finds the output still occupied holds its byte until the
// receiver takes the previous one.
// Depends on tadu_pkg, tadu_ram and assert_macros.svh.
`include "assert_macros.svh"

module temporal_average_upscale_dither (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  tadu_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output tadu_pkg::out_t out_data
);
  import tadu_pkg::*;

  // ---------------------------------------------------------------- state
  state_t             state_r, state_nxt;
  logic [HADDR_W-1:0] clr_r, clr_nxt;

  // write side: raster position, history slot and its base address
  logic [POS_W-1:0]   wpos_r, wpos_nxt;
  logic [SLOT_W-1:0]  slot_r, slot_nxt;
  logic [HADDR_W-1:0] hbase_r, hbase_nxt;
  logic [7:0]         pixel_r, pixel_nxt;

  // read side: display row/byte column, tracked without division
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [PH_W-1:0]    row_ph_r, row_ph_nxt;     // row mod SCALE
  logic [POS_W-1:0]   row_base_r, row_base_nxt; // (row / SCALE) * SRC_WIDTH
  logic [BCOL_W-1:0]  bcol_r, bcol_nxt;
  logic [SX_W-1:0]    byte_sx_r, byte_sx_nxt;   // first source column of byte
  logic [PH_W-1:0]    byte_ph_r, byte_ph_nxt;   // its phase in that column

  // byte assembly cursor
  logic [SX_W-1:0]    cur_sx_r, cur_sx_nxt;
  logic [PH_W-1:0]    cur_ph_r, cur_ph_nxt;
  logic [BIT_W-1:0]   cur_b_r, cur_b_nxt;
  logic [7:0]         acc_r, acc_nxt;
  grp_t               d1_r, d1_nxt;

  logic               out_valid_r, out_valid_nxt;
  out_t               out_data_r, out_data_nxt;

  // ---------------------------------------------------------------- stores
  logic               sum_we, hist_we;
  logic [POS_W-1:0]   sum_addr;
  logic [HADDR_W-1:0] hist_addr;
  logic [7:0]         sum_wdata, hist_wdata, sum_rdata, hist_rdata;

  tadu_ram #(.DEPTH(PIX_COUNT), .WIDTH(8)) u_sum (
    .clk   (clk),
    .we    (sum_we),
    .addr  (sum_addr),
    .wdata (sum_wdata),
    .rdata (sum_rdata)
  );

  tadu_ram #(.DEPTH(HIST_DEPTH), .WIDTH(8)) u_hist (
    .clk   (clk),
    .we    (hist_we),
    .addr  (hist_addr),
    .wdata (hist_wdata),
    .rdata (hist_rdata)
  );

  // ---------------------------------------------------------------- dither
  // Compare the returned sum against the thresholds of the bits it covers.
  logic [7:0] grp_bits;

  always_comb begin
    grp_bits = '0;
    for (int b = 0; b < 8; b++) begin
      if (d1_r.valid && d1_r.col_ok && (BIT_W'(b) >= d1_r.start) &&
          (BIT_W'(b) < d1_r.start + d1_r.cnt) &&
          (sum_rdata >= THRESH[2'(b)][row_r[1:0]])) begin
        grp_bits[3'(7 - b)] = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- control
  logic             in_fire;
  logic             out_free;
  logic [BIT_W-1:0] rem_ph, rem_b, grp_n;
  logic             col_ok;
  logic             last_byte;
  logic [PH_W:0]    ph_sum;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  assign rem_ph    = BIT_W'(SCALE) - BIT_W'(cur_ph_r);
  assign rem_b     = BIT_W'(8) - cur_b_r;
  assign grp_n     = (rem_ph < rem_b) ? rem_ph : rem_b;
  assign col_ok    = (cur_sx_r < SX_W'(SRC_WIDTH));
  assign last_byte = (row_r == ROW_W'(DISP_HEIGHT - 1)) &&
                     (bcol_r == BCOL_W'(BYTES_PER_ROW - 1));
  assign ph_sum    = (PH_W + 1)'(byte_ph_r) + (PH_W + 1)'(BYTE_REM);

  always_comb begin
    state_nxt    = state_r;
    clr_nxt      = clr_r;
    wpos_nxt     = wpos_r;
    slot_nxt     = slot_r;
    hbase_nxt    = hbase_r;
    pixel_nxt    = pixel_r;
    row_nxt      = row_r;
    row_ph_nxt   = row_ph_r;
    row_base_nxt = row_base_r;
    bcol_nxt     = bcol_r;
    byte_sx_nxt  = byte_sx_r;
    byte_ph_nxt  = byte_ph_r;
    cur_sx_nxt   = cur_sx_r;
    cur_ph_nxt   = cur_ph_r;
    cur_b_nxt    = cur_b_r;
    acc_nxt      = acc_r;
    d1_nxt       = '0;
    out_data_nxt = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;

    // idle default: address both stores at the current write position
    sum_we     = 1'b0;
    hist_we    = 1'b0;
    sum_addr   = wpos_r;
    hist_addr  = hbase_r + HADDR_W'(wpos_r);
    sum_wdata  = sum_rdata + pixel_r - hist_rdata;
    hist_wdata = pixel_r;

    unique case (state_r)
      ST_CLEAR: begin
        hist_we    = 1'b1;
        hist_addr  = clr_r;
        hist_wdata = '0;
        sum_we     = (clr_r < HADDR_W'(PIX_COUNT));
        sum_addr   = clr_r[POS_W-1:0];
        sum_wdata  = '0;
        clr_nxt    = clr_r + 1'b1;
        if (clr_r == HADDR_W'(HIST_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_fire) begin
          if (in_data.kind == KIND_WRITE) begin
            pixel_nxt = in_data.pixel;
            state_nxt = ST_WR_WRITE;
          end else begin
            cur_sx_nxt = byte_sx_r;
            cur_ph_nxt = byte_ph_r;
            cur_b_nxt  = '0;
            acc_nxt    = '0;
            state_nxt  = ST_RD_ISSUE;
          end
        end
      end

      ST_WR_WRITE: begin
        // read data of sum and history arrived; write both back
        sum_we  = 1'b1;
        hist_we = 1'b1;
        if (wpos_r == POS_W'(PIX_COUNT - 1)) begin
          wpos_nxt = '0;
          if (slot_r == SLOT_W'(HISTORY_FRAMES - 1)) begin
            slot_nxt  = '0;
            hbase_nxt = '0;
          end else begin
            slot_nxt  = slot_r + 1'b1;
            hbase_nxt = hbase_r + HADDR_W'(PIX_COUNT);
          end
        end else begin
          wpos_nxt = wpos_r + 1'b1;
        end
        state_nxt = ST_IDLE;
      end

      ST_RD_ISSUE: begin
        // one source column per cycle; padding columns read a dummy address and are masked
        sum_addr     = col_ok ? (row_base_r + POS_W'(cur_sx_r)) : row_base_r;
        d1_nxt.valid  = 1'b1;
        d1_nxt.col_ok = col_ok;
        d1_nxt.start  = cur_b_r;
        d1_nxt.cnt    = grp_n;
        acc_nxt      = acc_r | grp_bits;
        cur_b_nxt    = cur_b_r + grp_n;
        cur_sx_nxt   = cur_sx_r + 1'b1;
        cur_ph_nxt   = '0;
        if (cur_b_r + grp_n == BIT_W'(8)) begin
          state_nxt = ST_RD_DRAIN;
        end
      end

      ST_RD_DRAIN: begin
        acc_nxt   = acc_r | grp_bits;
        state_nxt = ST_RD_HOLD;
      end

      ST_RD_HOLD: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.out_byte  = acc_r;
          out_data_nxt.frame_end = last_byte;
          state_nxt              = ST_IDLE;
          if (bcol_r == BCOL_W'(BYTES_PER_ROW - 1)) begin
            bcol_nxt    = '0;
            byte_sx_nxt = '0;
            byte_ph_nxt = '0;
            if (row_r == ROW_W'(DISP_HEIGHT - 1)) begin
              row_nxt      = '0;
              row_ph_nxt   = '0;
              row_base_nxt = '0;
            end else begin
              row_nxt = row_r + 1'b1;
              if (row_ph_r == PH_W'(SCALE - 1)) begin
                row_ph_nxt   = '0;
                row_base_nxt = row_base_r + POS_W'(SRC_WIDTH);
              end else begin
                row_ph_nxt = row_ph_r + 1'b1;
              end
            end
          end else begin
            bcol_nxt = bcol_r + 1'b1;
            if (ph_sum >= (PH_W + 1)'(SCALE)) begin
              byte_ph_nxt = PH_W'(ph_sum - (PH_W + 1)'(SCALE));
              byte_sx_nxt = byte_sx_r + SX_W'(BYTE_STEP + 1);
            end else begin
              byte_ph_nxt = PH_W'(ph_sum);
              byte_sx_nxt = byte_sx_r + SX_W'(BYTE_STEP);
            end
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      wpos_r      <= '0;
      slot_r      <= '0;
      hbase_r     <= '0;
      row_r       <= '0;
      row_ph_r    <= '0;
      row_base_r  <= '0;
      bcol_r      <= '0;
      byte_sx_r   <= '0;
      byte_ph_r   <= '0;
      cur_sx_r    <= '0;
      cur_ph_r    <= '0;
      cur_b_r     <= '0;
      d1_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      wpos_r      <= wpos_nxt;
      slot_r      <= slot_nxt;
      hbase_r     <= hbase_nxt;
      row_r       <= row_nxt;
      row_ph_r    <= row_ph_nxt;
      row_base_r  <= row_base_nxt;
      bcol_r      <= bcol_nxt;
      byte_sx_r   <= byte_sx_nxt;
      byte_ph_r   <= byte_ph_nxt;
      cur_sx_r    <= cur_sx_nxt;
      cur_ph_r    <= cur_ph_nxt;
      cur_b_r     <= cur_b_nxt;
      d1_r        <= d1_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    pixel_r    <= pixel_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------- checks
  // sum-store reads in flight belong to byte assembly only
  `TADU_ASSERT_NOW(a_d1_in_read, clk, rst_n, d1_r.valid,
    (state_r == ST_RD_ISSUE) || (state_r == ST_RD_DRAIN))
  // the sum store is written only by the clear pass and the pixel update
  `TADU_ASSERT_NOW(a_sum_we_src, clk, rst_n, sum_we,
    (state_r == ST_CLEAR) || (state_r == ST_WR_WRITE))
  // the bit cursor never runs past the byte while issuing
  `TADU_ASSERT_NOW(a_cursor_range, clk, rst_n, state_r == ST_RD_ISSUE,
    cur_b_r < BIT_W'(8))
  // a loaded byte always follows an assembled read
  `TADU_ASSERT_NEXT(a_load_after_hold, clk, rst_n,
    (state_r == ST_RD_HOLD) && out_free, out_valid_r && (state_r == ST_IDLE))

endmodule
